// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the positioner RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define VBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define VBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define VBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/vbb_pkg.sv -----
// Shared types and constants for the valve bang-bang positioner.
package vbb_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DEG     = 3'd0,
        REG_ADC_OPEN_END   = 3'd1,
        REG_ADC_CLOSE_END  = 3'd2,
        REG_KICK_WINDOW    = 3'd3,
        REG_STALL_TIMEOUT  = 3'd4,
        REG_MOVE_TIMEOUT   = 3'd5,
        REG_PROGRESS_MIN   = 3'd6,
        REG_END_BAND       = 3'd7
    } cfg_idx_t;

    // Register reset values.
    localparam logic [6:0]  RST_TARGET_DEG    = 7'd0;
    localparam logic [11:0] RST_ADC_OPEN_END  = 12'd2500;
    localparam logic [11:0] RST_ADC_CLOSE_END = 12'd1500;
    localparam logic [15:0] RST_KICK_WINDOW   = 16'd120;
    localparam logic [15:0] RST_STALL_TIMEOUT = 16'd1500;
    localparam logic [15:0] RST_MOVE_TIMEOUT  = 16'd10000;
    localparam logic [11:0] RST_PROGRESS_MIN  = 12'd8;
    localparam logic [11:0] RST_END_BAND      = 12'd60;

    // Drive and status codes.
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_ACW  = 2'd1,
        DIR_CW   = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MOVING  = 3'd1,
        ST_REACHED = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_INVALID = 3'd4,
        ST_STALL   = 3'd5,
        ST_ENDSTOP = 3'd6
    } status_t;

    localparam logic [7:0] DUTY_OFF    = 8'd0;
    localparam logic [7:0] DUTY_TRAVEL = 8'd210;
    localparam logic [7:0] DUTY_BREAK  = 8'd220;

    // Angle thresholds in hundredths of a degree.
    localparam logic [16:0]        TOL_CENTI      = 17'd200;
    localparam logic [16:0]        APPROACH_CENTI = 17'd800;
    localparam logic signed [15:0] OPEN_CENTI     = 16'sd8800;
    localparam logic signed [15:0] CLOSE_CENTI    = 16'sd200;
    localparam logic [6:0]         CENTI_PER_DEG  = 7'd100;

    // Configuration register bank.
    typedef struct packed {
        logic [6:0]  target_deg;
        logic [11:0] adc_open_end;
        logic [11:0] adc_close_end;
        logic [15:0] kick_window_ms;
        logic [15:0] stall_limit_ms;
        logic [15:0] move_limit_ms;
        logic [11:0] progress_min_counts;
        logic [11:0] end_band_counts;
    } cfg_t;

    // One result word.
    typedef struct packed {
        dir_t       drive_dir;
        logic [7:0] drive_duty;
        logic       pulse_mode;
        status_t    status;
        logic       fault_led;
        logic       is_open;
        logic       is_shut;
    } res_t;

endpackage

// ----- rtl/core/vbb_cfg_regs.sv -----
// Configuration register bank of the positioner.
module vbb_cfg_regs
    import vbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Writes are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Register writes, truncated to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_deg          <= RST_TARGET_DEG;
            cfg_reg.adc_open_end        <= RST_ADC_OPEN_END;
            cfg_reg.adc_close_end       <= RST_ADC_CLOSE_END;
            cfg_reg.kick_window_ms      <= RST_KICK_WINDOW;
            cfg_reg.stall_limit_ms      <= RST_STALL_TIMEOUT;
            cfg_reg.move_limit_ms       <= RST_MOVE_TIMEOUT;
            cfg_reg.progress_min_counts <= RST_PROGRESS_MIN;
            cfg_reg.end_band_counts     <= RST_END_BAND;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_DEG:    cfg_reg.target_deg          <= cfg_data[6:0];
                REG_ADC_OPEN_END:  cfg_reg.adc_open_end        <= cfg_data[11:0];
                REG_ADC_CLOSE_END: cfg_reg.adc_close_end       <= cfg_data[11:0];
                REG_KICK_WINDOW:   cfg_reg.kick_window_ms      <= cfg_data;
                REG_STALL_TIMEOUT: cfg_reg.stall_limit_ms      <= cfg_data;
                REG_MOVE_TIMEOUT:  cfg_reg.move_limit_ms       <= cfg_data;
                REG_PROGRESS_MIN:  cfg_reg.progress_min_counts <= cfg_data[11:0];
                REG_END_BAND:      cfg_reg.end_band_counts     <= cfg_data[11:0];
            endcase
        end
    end

endmodule

// ----- rtl/core/vbb_ctrl.sv -----
// Move state and per-sample drive decision of the positioner.
module vbb_ctrl
    import vbb_pkg::*;
#(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cfg_t                 cfg,
    input  logic                 start_move,
    input  logic [ADC_BITS-1:0]  adc_sample,
    input  logic [15:0]          angle_centi,
    input  logic [TIME_BITS-1:0] now_ms,
    output res_t                 res
);

    logic                 move_active_reg, move_active_next;
    logic [TIME_BITS-1:0] move_start_ms_reg, move_start_ms_next;
    logic [TIME_BITS-1:0] progress_ms_reg, progress_ms_next;
    logic [ADC_BITS-1:0]  last_progress_adc_reg, last_progress_adc_next;

    logic                 active;
    logic [TIME_BITS-1:0] start_ms;
    logic [TIME_BITS-1:0] lp_ms;
    logic [ADC_BITS-1:0]  lp_adc;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] idle_time;
    logic [13:0]          target_centi;
    logic signed [17:0]   err;
    logic [16:0]          aerr;
    logic                 kick;
    logic [ADC_BITS-1:0]  open_end;
    logic [ADC_BITS-1:0]  close_end;
    logic [ADC_BITS-1:0]  d_progress;
    logic [ADC_BITS-1:0]  d_open;
    logic [ADC_BITS-1:0]  d_close;
    logic                 moved;
    logic                 stalled;
    logic                 end_zone;
    logic                 done;
    logic [15:0]          open_ext;
    logic [15:0]          close_ext;

    // Absolute difference of two ADC counts.
    function automatic logic [ADC_BITS-1:0] adc_dist(input logic [ADC_BITS-1:0] a,
                                                     input logic [ADC_BITS-1:0] b);
        adc_dist = (a >= b) ? (a - b) : (b - a);
    endfunction

    // A start flag restarts the move with this very sample.
    assign active   = start_move | move_active_reg;
    assign start_ms = start_move ? now_ms : move_start_ms_reg;
    assign lp_ms    = start_move ? now_ms : progress_ms_reg;
    assign lp_adc   = start_move ? adc_sample : last_progress_adc_reg;

    // Elapsed times wrap with the time stamp.
    assign elapsed   = now_ms - start_ms;
    assign idle_time = now_ms - lp_ms;
    assign kick      = elapsed < TIME_BITS'(cfg.kick_window_ms);

    // Angle error in hundredths of a degree.
    assign target_centi = 14'(cfg.target_deg) * 14'(CENTI_PER_DEG);
    assign err  = $signed({4'b0, target_centi}) - 18'(signed'(angle_centi));
    assign aerr = err[17] ? 17'(-err) : 17'(err);

    // Calibrated ends brought to the ADC width.
    assign open_ext  = 16'(cfg.adc_open_end);
    assign close_ext = 16'(cfg.adc_close_end);
    assign open_end  = open_ext[ADC_BITS-1:0];
    assign close_end = close_ext[ADC_BITS-1:0];

    // Progress and stall tests.
    assign d_progress = adc_dist(adc_sample, lp_adc);
    assign d_open     = adc_dist(adc_sample, open_end);
    assign d_close    = adc_dist(adc_sample, close_end);
    assign moved      = 16'(d_progress) >= 16'(cfg.progress_min_counts);
    assign stalled    = idle_time > TIME_BITS'(cfg.stall_limit_ms);
    assign end_zone   = (16'(d_open) < 16'(cfg.end_band_counts)) ||
                        (16'(d_close) < 16'(cfg.end_band_counts));

    // Decision for one sample, in priority order.
    always_comb
    begin
        res                    = '0;
        res.drive_dir          = DIR_STOP;
        res.status             = ST_IDLE;
        res.is_open            = $signed(angle_centi) >= OPEN_CENTI;
        res.is_shut            = $signed(angle_centi) <= CLOSE_CENTI;
        done                   = 1'b0;
        move_start_ms_next     = start_ms;
        progress_ms_next       = lp_ms;
        last_progress_adc_next = lp_adc;

        if (active)
        begin
            if (angle_centi[15])
            begin
                res.status    = ST_INVALID;
                res.fault_led = 1'b1;
                done          = 1'b1;
            end
            else if (aerr <= TOL_CENTI)
            begin
                res.status = ST_REACHED;
                done       = 1'b1;
            end
            else
            begin
                res.drive_dir = err[17] ? DIR_CW : (err == '0 ? DIR_CW : DIR_ACW);
                if (!kick && aerr < APPROACH_CENTI)
                begin
                    res.drive_duty = DUTY_TRAVEL;
                    res.pulse_mode = 1'b1;
                end
                else
                begin
                    res.drive_duty = kick ? DUTY_BREAK : DUTY_TRAVEL;
                end
                res.status = ST_MOVING;

                // Progress tracking; stall checks are held off during the kick.
                if (kick || moved)
                begin
                    last_progress_adc_next = adc_sample;
                    progress_ms_next       = now_ms;
                end
                else if (stalled)
                begin
                    res.status    = end_zone ? ST_ENDSTOP : ST_STALL;
                    res.fault_led = !end_zone;
                    done          = 1'b1;
                end

                // Hard limit on the whole move.
                if (!done && elapsed > TIME_BITS'(cfg.move_limit_ms))
                begin
                    res.status    = ST_TIMEOUT;
                    res.fault_led = 1'b1;
                    done          = 1'b1;
                end
            end

            if (done)
            begin
                res.drive_dir  = DIR_STOP;
                res.drive_duty = DUTY_OFF;
                res.pulse_mode = 1'b0;
            end
        end
    end

    assign move_active_next = active && !done;

    // Move state advances once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_active_reg       <= 1'b0;
            move_start_ms_reg     <= '0;
            progress_ms_reg       <= '0;
            last_progress_adc_reg <= '0;
        end
        else if (step)
        begin
            move_active_reg       <= move_active_next;
            move_start_ms_reg     <= move_start_ms_next;
            progress_ms_reg       <= progress_ms_next;
            last_progress_adc_reg <= last_progress_adc_next;
        end
    end

endmodule

// ----- rtl/core/valve_bang_bang_positioner_core.sv -----
// Top level of the valve bang-bang positioner: sample register, decision, result register.
//
// Usage: each input word is one position sample (start_move, adc_sample,
// angle_centi, now_ms), taken when in_valid is high and in_stall is low. Each
// sample yields exactly one result word (drive_dir, drive_duty, pulse_mode,
// status, fault_led, is_open, is_shut), offered with out_valid and taken
// when out_stall is low.
// Path: a taken sample sits in the sample register until the result register
// is free or being taken, and the decision logic then loads the result
// register and raises out_valid. Throughput is one sample per cycle while
// out_stall is low; the decision is a single pass of compares, subtracts and
// a multiply on the sample and the move state.
// While the receiver stalls a held result, one more sample fills the sample
// register, and then in_stall stays high until the result is taken; nothing
// is dropped.
// Configuration writes are accepted every cycle (cfg_ready stays high) and
// must be made only while no sample is in flight.
// Reset clears the pipeline valids and the move state and loads the
// register defaults; the block is ready as soon as reset is released.
module valve_bang_bang_positioner_core
    import vbb_pkg::*;
#(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  start_move,
    input  logic [ADC_BITS-1:0]   adc_sample,
    input  logic [15:0]           angle_centi,
    input  logic [TIME_BITS-1:0]  now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            drive_dir,
    output logic [7:0]            drive_duty,
    output logic                  pulse_mode,
    output logic [2:0]            status,
    output logic                  fault_led,
    output logic                  is_open,
    output logic                  is_shut
);

`include "assert_macros.svh"

    cfg_t                 cfg;
    res_t                 res;
    res_t                 out_res_reg;
    logic                 out_valid_reg;
    logic                 s1_valid_reg;
    logic                 s1_start_reg;
    logic [ADC_BITS-1:0]  s1_adc_reg;
    logic [15:0]          s1_angle_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 advance;
    logic                 in_take;

    vbb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The sample moves on whenever the result register is free or being taken.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    vbb_ctrl #(
        .ADC_BITS  (ADC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cfg         (cfg),
        .start_move  (s1_start_reg),
        .adc_sample  (s1_adc_reg),
        .angle_centi (s1_angle_reg),
        .now_ms      (s1_now_reg),
        .res         (res)
    );

    // Sample register valid and result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Sample payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_start_reg <= start_move;
            s1_adc_reg   <= adc_sample;
            s1_angle_reg <= angle_centi;
            s1_now_reg   <= now_ms;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign drive_dir  = out_res_reg.drive_dir;
    assign drive_duty = out_res_reg.drive_duty;
    assign pulse_mode = out_res_reg.pulse_mode;
    assign status     = out_res_reg.status;
    assign fault_led  = out_res_reg.fault_led;
    assign is_open    = out_res_reg.is_open;
    assign is_shut    = out_res_reg.is_shut;

    // A processed sample always lands in the result register.
    `VBB_ASSERT_NXT(a_advance_loads, clk, rst_n, advance, out_valid_reg)
    // A finished move never leaves the motor driven.
    `VBB_ASSERT_IMP(a_stop_on_end, clk, rst_n,
        out_valid_reg && status != ST_IDLE && status != ST_MOVING,
        drive_dir == DIR_STOP && drive_duty == DUTY_OFF && !pulse_mode)
    // The fault indicator only accompanies timeout, invalid and stall.
    `VBB_ASSERT_IMP(a_fault_codes, clk, rst_n, out_valid_reg && fault_led,
        status == ST_TIMEOUT || status == ST_INVALID || status == ST_STALL)
    // Pulse mode is only used while moving at run duty.
    `VBB_ASSERT_IMP(a_pulse_run, clk, rst_n, out_valid_reg && pulse_mode,
        status == ST_MOVING && drive_duty == DUTY_TRAVEL)

endmodule
